// ===== hdl/mbrc_pkg.sv =====
// Shared types, codes and the CRC-16/MODBUS byte update for the RTU request classifier.
// Used by mbrc_classify, modbus_rtu_request_classifier_top and the testbench; no dependencies.
`default_nettype none

package mbrc_pkg;

    // Length counter width and its saturation value
    localparam int unsigned LEN_BITS = 9;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // Reported frame length: nine bits, held at its maximum for longer frames
    localparam int unsigned LEN_OUT_BITS = 9;
    localparam logic [LEN_OUT_BITS-1:0] LEN_OUT_MAX = {LEN_OUT_BITS{1'b1}};

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Frame limits
    localparam logic [LEN_BITS-1:0] MIN_FRAME = LEN_BITS'(8);
    localparam logic [LEN_BITS-1:0] MIN_CRC_LEN = LEN_BITS'(3);
    localparam logic [17:0] MULTI_MIN = 18'd9;    // header, byte count and CRC
    localparam int unsigned HDR_DEPTH = 6;

    // Function codes
    localparam logic [7:0] FN_READ   = 8'h03;
    localparam logic [7:0] FN_WRITE1 = 8'h06;
    localparam logic [7:0] FN_DIAG   = 8'h08;
    localparam logic [7:0] FN_WRITEN = 8'h10;

    // Exception codes as sent on the wire
    localparam logic [1:0] EXC_NONE  = 2'd0;
    localparam logic [1:0] EXC_FUNC  = 2'd1;
    localparam logic [1:0] EXC_VALUE = 2'd3;

    typedef enum logic [2:0] {
        ACT_IGNORE = 3'd0,
        ACT_READ   = 3'd1,
        ACT_WRITE1 = 3'd2,
        ACT_WRITEN = 3'd3,
        ACT_ECHO   = 3'd4,
        ACT_EXCEPT = 3'd5
    } t_action;

    typedef logic [7:0] t_header [HDR_DEPTH];

    typedef struct packed {
        logic                    crc_ok;
        logic [LEN_OUT_BITS-1:0] frame_length;
        logic [15:0]             single_value;
        logic [15:0]             register_count;
        logic [15:0]             start_address;
        logic [7:0]              fn_code;
        logic [7:0]              slave_address;
        logic [1:0]              exc_code;
        t_action                 action;
    } t_result;

    // One byte through the reflected CRC, bit by bit
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mbrc_classify.sv =====
// Decodes a finished request frame into its action, exception and header fields.
// Depends on mbrc_pkg; purely combinational, feeds the result register of the top level.
`default_nettype none

module mbrc_classify (
    input  mbrc_pkg::t_header                i_hdr,
    input  logic [mbrc_pkg::LEN_BITS-1:0]    i_len,
    input  logic                             i_crc_ok,
    output mbrc_pkg::t_result                o_res
);
    import mbrc_pkg::*;

    logic [15:0]             start;
    logic [15:0]             count;
    logic [17:0]             need_len;
    logic                    long_enough;
    logic [LEN_OUT_BITS-1:0] len_out;

    assign start       = {i_hdr[2], i_hdr[3]};
    assign count       = {i_hdr[4], i_hdr[5]};
    // 9 + 2*count, full width so a huge count never wraps
    assign need_len    = MULTI_MIN + {1'b0, count, 1'b0};
    assign long_enough = ({{(18-LEN_BITS){1'b0}}, i_len} >= need_len);
    // Reported length holds at its maximum when the counter is wider
    assign len_out     = (i_len > LEN_BITS'(LEN_OUT_MAX)) ? LEN_OUT_MAX
                                                          : i_len[LEN_OUT_BITS-1:0];

    always_comb begin
        o_res = '0;
        o_res.action       = ACT_IGNORE;
        o_res.frame_length = len_out;
        if (i_len >= MIN_FRAME) begin
            o_res.slave_address  = i_hdr[0];
            o_res.fn_code        = i_hdr[1];
            o_res.start_address  = start;
            o_res.register_count = count;
            o_res.crc_ok         = i_crc_ok;
            // Order matters: a bad CRC overrides any function decode
            priority if (!i_crc_ok) begin
                o_res.action   = ACT_EXCEPT;
                o_res.exc_code = EXC_VALUE;
            end else if (i_hdr[1] == FN_READ) begin
                o_res.action = ACT_READ;
            end else if (i_hdr[1] == FN_WRITE1) begin
                o_res.action         = ACT_WRITE1;
                o_res.single_value   = count;
                o_res.register_count = 16'd1;
            end else if (i_hdr[1] == FN_DIAG) begin
                if (start == 16'd0) begin
                    o_res.action = ACT_ECHO;
                end else begin
                    o_res.action   = ACT_EXCEPT;
                    o_res.exc_code = EXC_FUNC;
                end
            end else if (i_hdr[1] == FN_WRITEN) begin
                if (long_enough) begin
                    o_res.action = ACT_WRITEN;
                end else begin
                    o_res.action   = ACT_EXCEPT;
                    o_res.exc_code = EXC_VALUE;
                end
            end else begin
                o_res.action   = ACT_EXCEPT;
                o_res.exc_code = EXC_FUNC;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/modbus_rtu_request_classifier_top.sv =====
// Top level of the Modbus RTU request classifier: input register, CRC/length/header
// tracking and result register. Depends on mbrc_pkg and mbrc_classify.
//
//  channel   dir  payload                                       handshake
//  s (rx)    in   tdata[7:0] rx_byte, tlast last_byte           tvalid/tready
//  m (res)   out  tdata[79:0] classification (see port list)    tvalid/tready
//
// One byte per cycle unless a frame-end byte waits on a stalled result: each byte is
// held in the input register, where the unrolled eight-bit CRC update and the
// classification run, then the result word is registered.
// Reset (i_rst_n low, synchronous) empties both registers, sets the CRC to FFFF and
// the count to zero. A stalled result blocks only the frame-end byte behind it;
// bytes inside a frame keep flowing while the result waits.
`default_nettype none

module modbus_rtu_request_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] action, [4:3] exc_code, [12:5] slave_address, [20:13] fn_code,
    // [36:21] start_address, [52:37] register_count, [68:53] single_value,
    // [77:69] frame_length, [78] crc_ok, [79] zero
    output logic [79:0] o_m_tdata
);
    import mbrc_pkg::*;

    // Input register
    logic                r_in_vld;
    logic [7:0]          r_in_byte;
    logic                r_in_last;

    // Frame state
    logic [15:0]         r_crc,  n_crc;
    logic [LEN_BITS-1:0] r_cnt,  n_cnt;
    logic [7:0]          r_tail0;
    logic [7:0]          r_tail1;
    t_header             r_hdr;

    // Result register
    logic                r_out_vld;
    t_result             r_out;

    logic                out_free;
    logic                proc_go;
    logic [15:0]         crc_upd;
    logic                crc_ok;
    t_result             res;

    assign out_free   = !r_out_vld || i_m_tready;
    assign proc_go    = r_in_vld && (!r_in_last || out_free);
    assign o_s_tready = !r_in_vld || proc_go;

    // Input word capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // CRC runs two bytes behind so the received CRC never enters it
    always_comb begin
        crc_upd = (r_cnt >= LEN_BITS'(2)) ? crc_feed(r_crc, r_tail1) : r_crc;
        n_cnt   = (r_cnt != LEN_MAX) ? r_cnt + LEN_BITS'(1) : r_cnt;
        crc_ok  = (n_cnt >= MIN_CRC_LEN) && (crc_upd == {r_in_byte, r_tail0});
        n_crc   = r_in_last ? CRC_INIT : crc_upd;
    end

    mbrc_classify u_classify (
        .i_hdr    (r_hdr),
        .i_len    (n_cnt),
        .i_crc_ok (crc_ok),
        .o_res    (res)
    );

    // Frame tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_cnt   <= '0;
            r_tail0 <= '0;
            r_tail1 <= '0;
        end else if (proc_go) begin
            r_crc   <= n_crc;
            r_cnt   <= r_in_last ? '0 : n_cnt;
            r_tail1 <= r_tail0;
            r_tail0 <= r_in_byte;
        end
    end

    // Header bytes 0 to 5, no reset
    always_ff @(posedge i_clk) begin
        if (proc_go && (r_cnt < LEN_BITS'(HDR_DEPTH))) begin
            r_hdr[r_cnt[2:0]] <= r_in_byte;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc_go && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
        if (proc_go && r_in_last) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out.crc_ok, r_out.frame_length, r_out.single_value,
                         r_out.register_count, r_out.start_address, r_out.fn_code,
                         r_out.slave_address, r_out.exc_code, r_out.action};

endmodule

`default_nettype wire

// ===== tb/mbrc_checker.sv =====
// Checker for the Modbus RTU request classifier: watches both stream channels, predicts
// each classification word from the accepted bytes and compares it field by field.
// Depends on mbrc_pkg for the result layout, action codes and frame constants.
`timescale 1ns / 1ps

module mbrc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] rx_byte
    input  logic        i_s_tlast,      // last_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,      // classification word, t_result in [78:0]
    output int          o_fail_count,
    output int          o_outstanding
);
    import mbrc_pkg::*;

    // Shadow state of the frame tracker
    logic [15:0]         crc_acc;
    logic [LEN_BITS-1:0] byte_cnt;
    logic [7:0]          hdr [HDR_DEPTH];
    logic [7:0]          tail [2];       // [0] previous byte, [1] the one before

    t_result expected_words [$];

    // Bitwise reflected CRC-16, one byte
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        c = acc ^ {8'h00, d};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Advance the shadow tracker by one byte; on the frame end queue its classification
    task automatic track_byte(input logic [7:0] b, input logic last);
        logic [LEN_BITS-1:0] n;
        logic [15:0]         start_w;
        logic [15:0]         count_w;
        logic [15:0]         recv;
        logic [17:0]         need;
        logic                ok;
        t_result             r;
        n = byte_cnt;
        if (n >= 2) crc_acc = crc_step(crc_acc, tail[1]);
        if (n < HDR_DEPTH) hdr[n] = b;
        tail[1] = tail[0];
        tail[0] = b;
        if (n != LEN_MAX) byte_cnt = n + 1'b1;
        if (last) begin
            recv = {b, tail[1]};
            ok = (byte_cnt >= MIN_CRC_LEN) && (crc_acc == recv);
            r = '0;
            r.frame_length = (byte_cnt > LEN_BITS'(LEN_OUT_MAX)) ? LEN_OUT_MAX
                                                                 : byte_cnt[LEN_OUT_BITS-1:0];
            if (byte_cnt >= MIN_FRAME) begin
                start_w = {hdr[2], hdr[3]};
                count_w = {hdr[4], hdr[5]};
                r.slave_address  = hdr[0];
                r.fn_code        = hdr[1];
                r.start_address  = start_w;
                r.register_count = count_w;
                r.crc_ok         = ok;
                r.action         = ACT_EXCEPT;
                r.exc_code       = EXC_NONE;
                if (!ok) begin
                    r.exc_code = EXC_VALUE;
                end else begin
                    case (hdr[1])
                        FN_READ: begin
                            r.action = ACT_READ;
                        end
                        FN_WRITE1: begin
                            r.action         = ACT_WRITE1;
                            r.single_value   = count_w;
                            r.register_count = 16'd1;
                        end
                        FN_DIAG: begin
                            if (start_w == 16'h0000) r.action = ACT_ECHO;
                            else r.exc_code = EXC_FUNC;
                        end
                        FN_WRITEN: begin
                            // full-width length test, no wrap of 2 * count
                            need = MULTI_MIN + {1'b0, count_w, 1'b0};
                            if (18'(byte_cnt) >= need) r.action = ACT_WRITEN;
                            else r.exc_code = EXC_VALUE;
                        end
                        default: begin
                            r.exc_code = EXC_FUNC;
                        end
                    endcase
                end
            end
            expected_words.push_back(r);
            crc_acc  = CRC_INIT;
            byte_cnt = '0;
        end
    endtask

    // Sample both channels at the edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            crc_acc  = CRC_INIT;
            byte_cnt = '0;
            foreach (hdr[k]) hdr[k] = 8'h00;
            tail[0] = 8'h00;
            tail[1] = 8'h00;
            expected_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[78:0];
                if (expected_words.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result word, expected none actual %h",
                             $time, i_m_tdata);
                end else begin
                    want = expected_words.pop_front();
                    cmp_field("action", want.action, got.action);
                    cmp_field("exc_code", want.exc_code, got.exc_code);
                    cmp_field("slave_address", want.slave_address, got.slave_address);
                    cmp_field("fn_code", want.fn_code, got.fn_code);
                    cmp_field("start_address", want.start_address, got.start_address);
                    cmp_field("register_count", want.register_count, got.register_count);
                    cmp_field("single_value", want.single_value, got.single_value);
                    cmp_field("frame_length", want.frame_length, got.frame_length);
                    cmp_field("crc_ok", want.crc_ok, got.crc_ok);
                    cmp_field("pad bit", 0, i_m_tdata[79]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                track_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_outstanding = expected_words.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the Modbus RTU request classifier: clock, reset, frame stimulus,
// output back-pressure and the verdict. Depends on mbrc_pkg, mbrc_checker and the block.
`timescale 1ns / 1ps

module tb_top;
    import mbrc_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    int fail_count;
    int outstanding;

    // Shared between stimulus and receiver
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;

    logic [7:0] frame_q [$];
    int         bytes_sent = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    modbus_rtu_request_classifier_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    mbrc_checker u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 16-bit field value, extremes often
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_function();
        case ($urandom_range(0, 9))
            0, 1:    return FN_READ;
            2, 3:    return FN_WRITE1;
            4, 5:    return FN_DIAG;
            6, 7:    return FN_WRITEN;
            default: return 8'($urandom);
        endcase
    endfunction

    // Append the CRC, low byte first as on the wire
    task automatic add_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_q[k]) c = crc_feed(c, frame_q[k]);
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endtask

    // Request with random content and a valid CRC; multiple writes may carry short data
    task automatic build_request(input logic [7:0] fn);
        logic [15:0] start_w;
        logic [15:0] count_w;
        int          n;
        frame_q.delete();
        frame_q.push_back(8'($urandom));
        frame_q.push_back(fn);
        start_w = (fn == FN_DIAG && $urandom_range(0, 3) != 0) ? 16'h0000 : pick_word();
        count_w = (fn == FN_WRITEN && $urandom_range(0, 4) != 0) ?
                  16'($urandom_range(0, 6)) : pick_word();
        frame_q.push_back(start_w[15:8]);
        frame_q.push_back(start_w[7:0]);
        frame_q.push_back(count_w[15:8]);
        frame_q.push_back(count_w[7:0]);
        if (fn == FN_WRITEN) begin
            frame_q.push_back(8'(count_w << 1));
            n = (count_w <= 6) ? 2 * count_w : 0;
            // sometimes cut the data short of the declared count
            if (n > 0 && $urandom_range(0, 3) == 0) n = $urandom_range(0, n - 1);
        end else begin
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        end
        repeat (n) frame_q.push_back(8'($urandom));
        add_crc();
    endtask

    // Offer the bytes of frame_q one word at a time, last flag on the final byte
    task automatic send_frame(input bit with_gaps);
        for (int i = 0; i < frame_q.size(); i++) begin
            if (with_gaps && $urandom_range(0, 3) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_q[i];
            s_tlast  <= (i == frame_q.size() - 1);
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            bytes_sent++;
        end
    endtask

    // Stimulus and verdict
    initial begin
        int frame_no;
        int total;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: one-byte frame, short frame of all ones, read with extreme fields,
        // diagnostics echo with all-zero fields
        frame_q = '{8'h00};
        send_frame(1'b0);
        frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame(1'b0);
        frame_q = '{8'hFF, FN_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        add_crc();
        send_frame(1'b0);
        frame_q = '{8'h00, FN_DIAG, 8'h00, 8'h00, 8'h00, 8'h00};
        add_crc();
        send_frame(1'b1);

        // random frames
        frame_no = 0;
        while (bytes_sent < 1950) begin
            quiet = (bytes_sent > 1650);
            if (frame_no == 12) begin
                // one long multiple write that runs the length counter into saturation
                frame_q = '{8'($urandom), FN_WRITEN, 8'($urandom), 8'($urandom),
                            8'h00, 8'h02, 8'h04};
                total = $urandom_range(512, 530);
                while (frame_q.size() < total - 2) frame_q.push_back(8'($urandom));
                add_crc();
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:59]: begin
                        build_request(pick_function());
                    end
                    [60:74]: begin
                        build_request(pick_function());
                        frame_q[frame_q.size() - 1 - $urandom_range(0, 1)] ^=
                            8'(1 << $urandom_range(0, 7));
                    end
                    [75:87]: begin
                        frame_q.delete();
                        repeat ($urandom_range(1, 7)) frame_q.push_back(8'($urandom));
                    end
                    default: begin
                        frame_q.delete();
                        repeat ($urandom_range(8, 24)) frame_q.push_back(8'($urandom));
                    end
                endcase
            end
            if (frame_no == 25) hold_request = 1'b1;
            send_frame(!quiet && $urandom_range(0, 3) != 0);
            frame_no++;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // drain, then let the pipeline settle
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Result side: random stall bursts, one long hold-off on request, none at the end
    initial begin
        int held;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (held = 0; held < 400; held++) @(posedge clk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat (quiet ? 1 : ($urandom_range(0, 5) == 0 ? 120 : $urandom_range(1, 30)))
                    @(posedge clk);
            end
        end
    end

    // Watchdog
    initial begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
